FILE: hw/rtl/tpcv_pkg.sv
`default_nettype none

package tpcv_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int NUM_CAND   = 6;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef point_t [2:0] tri_t;

    // determinant kept as its two products, sign found by comparing them
    typedef struct packed {
        prod_t lhs;
        prod_t rhs;
    } det_prod_t;

    typedef struct packed {
        coord_t a0_x;
        coord_t a0_y;
        coord_t a1_x;
        coord_t a1_y;
        coord_t a2_x;
        coord_t a2_y;
        coord_t b0_x;
        coord_t b0_y;
        coord_t b1_x;
        coord_t b1_y;
        coord_t b2_x;
        coord_t b2_y;
    } in_word_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   empty_res;
        logic   last;
    } out_word_t;

    function automatic diff_t sub_ext(coord_t a, coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

    // products of (p - r) x (q - r)
    function automatic det_prod_t det_prods(point_t p, point_t q, point_t r);
        diff_t     u;
        diff_t     v;
        diff_t     s;
        diff_t     t;
        det_prod_t d;
        u = sub_ext(p.x, r.x);
        v = sub_ext(q.y, r.y);
        s = sub_ext(q.x, r.x);
        t = sub_ext(p.y, r.y);
        d.lhs = prod_t'(u) * prod_t'(v);
        d.rhs = prod_t'(s) * prod_t'(t);
        return d;
    endfunction

    function automatic logic det_nonneg(det_prod_t d);
        return d.lhs >= d.rhs;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tpcv_orient.sv
`default_nettype none

module tpcv_orient import tpcv_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     en,
    input  wire logic     orient_first,
    input  wire in_word_t in_word,
    output tri_t          tri_a,
    output tri_t          tri_b
);

    tri_t      raw_a;
    tri_t      raw_b;
    tri_t      tri_a1_reg;
    tri_t      tri_b1_reg;
    det_prod_t prod_a_reg;
    det_prod_t prod_b_reg;
    tri_t      tri_a2_reg;
    tri_t      tri_b2_reg;
    logic      swap_a;
    logic      swap_b;

    always_comb begin
        raw_a[0] = '{x: in_word.a0_x, y: in_word.a0_y};
        raw_a[1] = '{x: in_word.a1_x, y: in_word.a1_y};
        raw_a[2] = '{x: in_word.a2_x, y: in_word.a2_y};
        raw_b[0] = '{x: in_word.b0_x, y: in_word.b0_y};
        raw_b[1] = '{x: in_word.b1_x, y: in_word.b1_y};
        raw_b[2] = '{x: in_word.b2_x, y: in_word.b2_y};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tri_a1_reg <= raw_a;
            tri_b1_reg <= raw_b;
            prod_a_reg <= det_prods(raw_a[0], raw_a[1], raw_a[2]);
            prod_b_reg <= det_prods(raw_b[0], raw_b[1], raw_b[2]);
        end
    end

    // with orient_first set, clockwise or flat: swap vertices 0 and 1
    assign swap_a = orient_first && (prod_a_reg.lhs <= prod_a_reg.rhs);
    assign swap_b = orient_first && (prod_b_reg.lhs <= prod_b_reg.rhs);

    always_ff @(posedge aclk) begin
        if (en) begin
            tri_a2_reg <= swap_a ? {tri_a1_reg[2], tri_a1_reg[0], tri_a1_reg[1]} : tri_a1_reg;
            tri_b2_reg <= swap_b ? {tri_b1_reg[2], tri_b1_reg[0], tri_b1_reg[1]} : tri_b1_reg;
        end
    end

    assign tri_a = tri_a2_reg;
    assign tri_b = tri_b2_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tpcv_lane.sv
`default_nettype none

module tpcv_lane import tpcv_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   en,
    input  wire tri_t   shape,
    input  wire point_t cand,
    output point_t      cand_out,
    output logic        covered
);

    det_prod_t [2:0] prod_reg;
    point_t          cand3_reg;
    point_t          cand4_reg;
    logic            covered_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= det_prods(shape[0], shape[1], cand);
            prod_reg[1] <= det_prods(shape[1], shape[2], cand);
            prod_reg[2] <= det_prods(shape[2], shape[0], cand);
            cand3_reg   <= cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            covered_reg <= det_nonneg(prod_reg[0]) && det_nonneg(prod_reg[1])
                           && det_nonneg(prod_reg[2]);
            cand4_reg   <= cand3_reg;
        end
    end

    assign cand_out = cand4_reg;
    assign covered  = covered_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tpcv_merge.sv
`default_nettype none

module tpcv_merge import tpcv_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire point_t [NUM_CAND-1:0] in_pts,
    input  wire logic [NUM_CAND-1:0]   in_inside,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data
);

    logic [NUM_CAND-1:0]   keep;
    logic                  load;
    logic                  out_free;
    logic                  emit;
    logic [NUM_CAND-1:0]   pick;
    logic [NUM_CAND-1:0]   rem_after;
    logic                  is_last;
    point_t                pick_pt;

    logic                  buf_valid_reg;
    logic                  buf_valid_next;
    logic [NUM_CAND-1:0]   rem_reg;
    logic [NUM_CAND-1:0]   rem_next;
    point_t [NUM_CAND-1:0] pts_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    out_word_t             m_data_reg;
    out_word_t             m_data_next;

    // first occurrence wins among equal points
    always_comb begin
        for (int c = 0; c < NUM_CAND; c++) begin
            keep[c] = in_inside[c];
            for (int j = 0; j < c; j++) begin
                if (in_inside[j] && (in_pts[j] == in_pts[c])) begin
                    keep[c] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        pick      = rem_reg & (~rem_reg + 1'b1);
        rem_after = rem_reg & ~pick;
        is_last   = (rem_after == '0);
        pick_pt   = '0;
        for (int c = 0; c < NUM_CAND; c++) begin
            if (pick[c]) begin
                pick_pt = pts_reg[c];
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = buf_valid_reg && out_free;
    assign in_ready = !buf_valid_reg || (emit && is_last);
    assign load     = in_valid && in_ready;

    always_comb begin
        buf_valid_next = buf_valid_reg;
        rem_next       = rem_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            rem_next     = rem_after;
            if (is_last) begin
                buf_valid_next = 1'b0;
            end
            if (rem_reg == '0) begin
                m_data_next = '{point_x: '0, point_y: '0, empty_res: 1'b1, last: 1'b1};
            end else begin
                m_data_next = '{point_x: pick_pt.x, point_y: pick_pt.y,
                                empty_res: 1'b0, last: is_last};
            end
        end
        if (load) begin
            buf_valid_next = 1'b1;
            rem_next       = keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            buf_valid_reg <= buf_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
        if (load) begin
            pts_reg <= in_pts;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/triangle_pair_common_vertices_top.sv
`default_nettype none

// channel   dir  handshake          word
// s_        in   s_valid/s_ready    in_word_t: both triangles, 12 coordinates
// m_        out  m_valid/m_ready    out_word_t: point, empty_res, last
// cfg_      in   cfg_we             cfg_wdata: orient_first
//
// m_valid rises once a word has passed the orient, lane, merge buffer and output registers;
// results then follow one per cycle while m_ready is high. A pair occupies the output for its
// distinct points (1 to 6 words) or one empty result word, so pairs are taken back to back at
// the output's pace, limited by the single output register. A stall on m_ready holds the whole
// front pipeline once the result buffer is full. Reset clears all valid flags and orient_first.

module triangle_pair_common_vertices_top import tpcv_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_data,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata
);

    logic                  orient_first_reg;
    logic [3:0]            vld_reg;
    logic                  pipe_en;
    logic                  merge_ready;
    tri_t                  tri_a;
    tri_t                  tri_b;
    point_t [NUM_CAND-1:0] cand_pts;
    logic [NUM_CAND-1:0]   cand_inside;

    assign pipe_en = !vld_reg[3] || merge_ready;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_first_reg <= 1'b0;
            vld_reg          <= '0;
        end else begin
            if (cfg_we) begin
                orient_first_reg <= cfg_wdata;
            end
            if (pipe_en) begin
                vld_reg <= {vld_reg[2:0], s_valid};
            end
        end
    end

    tpcv_orient u_orient (
        .aclk         (aclk),
        .en           (pipe_en),
        .orient_first (orient_first_reg),
        .in_word      (s_data),
        .tri_a        (tri_a),
        .tri_b        (tri_b)
    );

    // even lanes: vertex of B against A, odd lanes: vertex of A against B
    for (genvar c = 0; c < NUM_CAND; c++) begin : g_lane
        tpcv_lane u_lane (
            .aclk     (aclk),
            .en       (pipe_en),
            .shape    ((c % 2 == 0) ? tri_a : tri_b),
            .cand     ((c % 2 == 0) ? tri_b[c / 2] : tri_a[c / 2]),
            .cand_out (cand_pts[c]),
            .covered  (cand_inside[c])
        );
    end

    tpcv_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[3]),
        .in_ready  (merge_ready),
        .in_pts    (cand_pts),
        .in_inside (cand_inside),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
